// File: hdl/rqss_pkg.sv
package rqss_pkg;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_POP    = 2'd1,
    FN_ROTATE = 2'd2,
    FN_REMOVE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  proc_id;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  count;
    logic [7:0]  head_id;
    logic [7:0]  tail_id;
    logic [7:0]  shortest_id;
    logic [15:0] shortest_burst;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_PUT,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: hdl/rqss_ram.sv
module rqss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/ready_queue_with_shortest_select_core.sv
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | in_item  (func, proc_id, burst_time)
// result  | out_valid | out_ready | out_item (status, count, ids, shortest)
//
// one item at a time; the queue lives in a circular ram (head pointer + count)
// append/pop/rotate: update head/count (append and rotate write the tail entry), then scan the ram
// remove by id: search up to count reads, then shift later entries down one place, each read then written
// worst case is remove (search, shift, then scan), limited by the single ram read port
// reset (rst_n low, synchronous) empties the queue; ram contents are not cleared
// a stalled result holds in out_item until taken; in_ready waits for it
module ready_queue_with_shortest_select_core #(
  parameter int DEPTH      = 16,
  parameter int BURST_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rqss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rqss_pkg::out_item_t out_item
);
  import rqss_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = 8 + BURST_BITS;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;      // logical position being worked on
  logic           pend_r, pend_nxt;    // a read is in flight (for idx_r-1 in find and scan)
  logic [1:0]     func_r, func_nxt;
  logic [7:0]     pid_r, pid_nxt;
  logic [BURST_BITS-1:0] bt_r, bt_nxt;
  logic [1:0]     stat_r, stat_nxt;
  logic [7:0]     hid_r, hid_nxt, tid_r, tid_nxt, sid_r, sid_nxt;
  logic [BURST_BITS-1:0] sb_r, sb_nxt;
  logic           sv_r, sv_nxt;        // shortest holds a value
  logic           ov_r, ov_nxt;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [EW-1:0]  wdata, rdata;
  logic [7:0]     rd_id;
  logic [BURST_BITS-1:0] rd_bt;

  rqss_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_id = rdata[EW-1 -: 8];
  assign rd_bt = rdata[BURST_BITS-1:0];

  // logical position to physical address
  function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] p);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, p[AW-1:0]};
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
    end
    idx_r  <= idx_nxt;
    func_r <= func_nxt;
    pid_r  <= pid_nxt;
    bt_r   <= bt_nxt;
    stat_r <= stat_nxt;
    hid_r  <= hid_nxt;
    tid_r  <= tid_nxt;
    sid_r  <= sid_nxt;
    sb_r   <= sb_nxt;
    sv_r   <= sv_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pend_nxt  = 1'b0;
    func_nxt  = func_r;
    pid_nxt   = pid_r;
    bt_nxt    = bt_r;
    stat_nxt  = stat_r;
    hid_nxt   = hid_r;
    tid_nxt   = tid_r;
    sid_nxt   = sid_r;
    sb_nxt    = sb_r;
    sv_nxt    = sv_r;
    ov_nxt    = ov_r;
    we        = 1'b0;
    waddr     = phys(head_r, idx_r);
    wdata     = {pid_r, bt_r};
    raddr     = phys(head_r, idx_r);
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          func_nxt = in_item.func;
          pid_nxt  = in_item.proc_id;
          bt_nxt   = BURST_BITS'(in_item.burst_time);
          stat_nxt = ST_OK;
          idx_nxt  = '0;
          state_nxt = S_SCAN;
          case (func_t'(in_item.func))
            FN_APPEND: begin
              if (cnt_r == CW'(DEPTH)) stat_nxt = ST_FULL;
              else state_nxt = S_PUT;
            end
            FN_POP: begin
              if (cnt_r == '0) stat_nxt = ST_EMPTY;
              else begin
                head_nxt = phys(head_r, CW'(1));
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            FN_ROTATE: begin
              // head moves to tail: read it then rewrite at old head + count
              if (cnt_r == '0) stat_nxt = ST_EMPTY;
              else if (cnt_r != CW'(1)) begin
                raddr = head_r;
                pend_nxt = 1'b1;
                state_nxt = S_PUT;
              end
            end
            default: begin
              if (cnt_r == '0) stat_nxt = ST_EMPTY;
              else begin
                raddr = head_r;
                idx_nxt = CW'(1);
                pend_nxt = 1'b1;
                state_nxt = S_FIND;
              end
            end
          endcase
        end
      end
      S_PUT: begin
        // append writes item at tail; rotate writes read head at tail
        we    = 1'b1;
        waddr = phys(head_r, cnt_r);
        if (func_t'(func_r) == FN_ROTATE) begin
          wdata    = rdata;
          head_nxt = phys(head_r, CW'(1));
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
        end
        idx_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_FIND: begin
        // rdata is entry idx_r-1
        if (rd_id == pid_r) begin
          idx_nxt = idx_r - 1'b1;   // position to fill
          state_nxt = S_SHIFT;
        end else if (idx_r == cnt_r) begin
          stat_nxt = ST_NOTFOUND;
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end else begin
          raddr = phys(head_r, idx_r);
          idx_nxt = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
      end
      S_SHIFT: begin
        // move entry idx_r+1 into idx_r; read then write
        if (idx_r + 1'b1 >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1;
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end else if (!pend_r) begin
          raddr = phys(head_r, idx_r + 1'b1);
          pend_nxt = 1'b1;
        end else begin
          we    = 1'b1;
          waddr = phys(head_r, idx_r);
          wdata = rdata;
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCAN: begin
        // issue read of idx_r, consume read of idx_r-1
        if (idx_r == '0) begin
          sv_nxt = 1'b0;
          hid_nxt = '0; tid_nxt = '0; sid_nxt = '0; sb_nxt = '0;
        end
        if (pend_r) begin
          if (idx_r == CW'(1)) hid_nxt = rd_id;
          tid_nxt = rd_id;
          if (!sv_r || rd_bt < sb_r) begin
            sid_nxt = rd_id;
            sb_nxt  = rd_bt;
            sv_nxt  = 1'b1;
          end
        end
        if (idx_r < cnt_r) begin
          raddr = phys(head_r, idx_r);
          idx_nxt = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_item                = '0;
    out_item.status         = stat_r;
    out_item.count          = 5'(cnt_r);
    out_item.head_id        = hid_r;
    out_item.tail_id        = tid_r;
    out_item.shortest_id    = sid_r;
    out_item.shortest_burst = 16'(sb_r);
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid) else $error("result not raised");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) - 1'b1
    || state_r == S_PUT) else $error("count jumped");
endmodule
